FILE: rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    // Framing bytes.
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // Control field codes.
    localparam logic [7:0] CTRL_I0   = 8'h00;
    localparam logic [7:0] CTRL_I1   = 8'h40;
    localparam logic [7:0] CTRL_DISC = 8'h0B;
    localparam logic [7:0] CTRL_RR0  = 8'h05;
    localparam logic [7:0] CTRL_RR1  = 8'h85;
    localparam logic [7:0] CTRL_REJ0 = 8'h01;
    localparam logic [7:0] CTRL_REJ1 = 8'h81;

    // Configuration registers.
    localparam int          CFG_IDX_W     = 1;
    localparam int          CFG_DATA_W    = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 1'b1;
    localparam logic [7:0]  ADDRESS_RESET = 8'h03;
    localparam logic [15:0] MAX_PAY_RESET = 16'd4096;

    // Receiver phase.
    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CTRL = 3'd2,
        PH_BCC1 = 3'd3,
        PH_DATA = 3'd4,
        PH_DBCC = 3'd5
    } t_phase;

    // Result kind.
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_DISC   = 2'd3
    } t_kind;

    // One result beat.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_result;

endpackage

FILE: rtl/stuffed_frame_receiver_top.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_rx_byte
// output    o_out_valid / i_out_ready    o_kind, o_value, o_last
// config    i_cfg_we (no handshake)      i_cfg_idx, i_cfg_data
//
// One line byte is taken per cycle while the output is not stalled; it passes
// an input register, is decoded against the frame state, and any result lands
// in the output register. Synchronous active-low reset clears the frame state
// and loads the default registers. While a result waits in the output register,
// the next byte stays undecoded in the input register and input ready drops
// once that is full.

module stuffed_frame_receiver_top import sfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_value,
    output logic                  o_last
);

    logic       stg_valid;
    logic [7:0] stg_byte;
    logic       can_load;
    logic       take;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // Decode a beat only when the output register can take its result.
    assign take = stg_valid && can_load;

    sfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_rx_byte),
        .i_take  (take),
        .o_valid (stg_valid),
        .o_byte  (stg_byte)
    );

    sfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_byte      (stg_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfr_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && res_valid),
        .i_res      (res),
        .i_ready    (i_out_ready),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .o_res      (out_res)
    );

    assign o_kind  = out_res.kind;
    assign o_value = out_res.value;
    assign o_last  = out_res.last;

endmodule

FILE: rtl/sfr_in_stage.sv
`timescale 1ns / 1ps

module sfr_in_stage import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       accept;

    // The register is free when empty or when its beat is consumed this cycle.
    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload holds until the next accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

FILE: rtl/sfr_core.sv
`timescale 1ns / 1ps

module sfr_core import sfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    output logic                  o_res_valid,
    output t_result               o_res
);

    logic [7:0]  r_address;
    logic [15:0] r_max_payload;

    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_esc;
    logic        n_esc;
    logic        r_held_valid;
    logic        n_held_valid;
    logic [7:0]  r_held_byte;
    logic [7:0]  n_held_byte;
    logic [7:0]  r_xor;
    logic [7:0]  n_xor;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic        r_seq;
    logic        n_seq;
    logic [7:0]  r_rx_ctrl;
    logic [7:0]  n_rx_ctrl;

    logic [7:0]  expect_ctrl;
    logic [7:0]  rej_ctrl;
    logic [7:0]  unesc;
    logic        clr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address     <= ADDRESS_RESET;
            r_max_payload <= MAX_PAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ADDRESS_BYTE: r_address     <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD:  r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign expect_ctrl = r_seq ? CTRL_I1 : CTRL_I0;
    assign rej_ctrl    = r_seq ? CTRL_REJ1 : CTRL_REJ0;

    // Unescaped data byte for the current beat.
    always_comb begin
        if (!r_esc) begin
            unesc = i_byte;
        end else if (i_byte == ESC_FLAG) begin
            unesc = FLAG_BYTE;
        end else begin
            unesc = ESC_BYTE;
        end
    end

    // Frame decoding for one beat.
    always_comb begin
        n_phase      = r_phase;
        n_esc        = r_esc;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_xor        = r_xor;
        n_count      = r_count;
        n_seq        = r_seq;
        n_rx_ctrl    = r_rx_ctrl;
        clr          = 1'b0;
        o_res_valid  = 1'b0;
        o_res.kind   = KIND_DATA;
        o_res.value  = r_held_byte;
        o_res.last   = 1'b0;

        if (i_take) begin
            case (r_phase)
                PH_ADDR: begin
                    if (i_byte == FLAG_BYTE) begin
                        n_phase = PH_ADDR;
                    end else if (i_byte == r_address) begin
                        n_phase = PH_CTRL;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_CTRL: begin
                    if (i_byte == FLAG_BYTE) begin
                        n_phase = PH_ADDR;
                    end else if (i_byte == expect_ctrl) begin
                        n_rx_ctrl = i_byte;
                        n_phase   = PH_BCC1;
                    end else if (i_byte == CTRL_DISC) begin
                        n_rx_ctrl = i_byte;
                        n_phase   = PH_DBCC;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_BCC1: begin
                    if (i_byte == (r_address ^ r_rx_ctrl)) begin
                        clr     = 1'b1;
                        n_phase = PH_DATA;
                    end else if (i_byte == FLAG_BYTE) begin
                        n_phase = PH_ADDR;
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_REJECT;
                        o_res.value = rej_ctrl;
                        o_res.last  = 1'b1;
                        n_phase     = PH_WAIT;
                    end
                end
                PH_DBCC: begin
                    if (i_byte == (r_address ^ CTRL_DISC)) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_DISC;
                        o_res.value = CTRL_DISC;
                        o_res.last  = 1'b1;
                        n_phase     = PH_WAIT;
                    end else if (i_byte == FLAG_BYTE) begin
                        n_phase = PH_ADDR;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_DATA: begin
                    if (i_byte == FLAG_BYTE) begin
                        // Closing flag: the held byte is the check byte.
                        if (!r_esc && r_count >= 16'd2 && r_held_valid) begin
                            o_res_valid = 1'b1;
                            o_res.last  = 1'b1;
                            if (r_xor == r_held_byte) begin
                                o_res.kind  = KIND_ACCEPT;
                                o_res.value = r_seq ? CTRL_RR0 : CTRL_RR1;
                                n_seq       = !r_seq;
                            end else begin
                                o_res.kind  = KIND_REJECT;
                                o_res.value = rej_ctrl;
                            end
                        end
                        clr     = 1'b1;
                        n_phase = PH_WAIT;
                    end else if (r_esc && i_byte != ESC_FLAG && i_byte != ESC_ESC) begin
                        // Bad escape sequence drops the frame.
                        clr     = 1'b1;
                        n_phase = PH_WAIT;
                    end else if (!r_esc && i_byte == ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else if (r_count >= r_max_payload) begin
                        // Overflow drops the frame.
                        clr     = 1'b1;
                        n_phase = PH_WAIT;
                    end else begin
                        n_esc = 1'b0;
                        if (r_held_valid) begin
                            o_res_valid = 1'b1;
                            n_xor       = r_xor ^ r_held_byte;
                        end
                        n_held_byte  = unesc;
                        n_held_valid = 1'b1;
                        n_count      = r_count + 16'd1;
                    end
                end
                default: begin
                    n_phase = (i_byte == FLAG_BYTE) ? PH_ADDR : PH_WAIT;
                end
            endcase
        end

        // Frame context cleared at frame start and end.
        if (clr) begin
            n_esc        = 1'b0;
            n_held_valid = 1'b0;
            n_held_byte  = '0;
            n_xor        = '0;
            n_count      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_esc        <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
            r_xor        <= '0;
            r_count      <= '0;
            r_seq        <= 1'b0;
            r_rx_ctrl    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_esc        <= n_esc;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_xor        <= n_xor;
            r_count      <= n_count;
            r_seq        <= n_seq;
            r_rx_ctrl    <= n_rx_ctrl;
        end
    end

endmodule

FILE: rtl/sfr_out_stage.sv
`timescale 1ns / 1ps

module sfr_out_stage import sfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // A new result may enter when the register is empty or drains this cycle.
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
